// ----- hdl/pic_pkg.sv -----
// ----------------------------------------------------------------------------
// pic_pkg: shared definitions of the priority interrupt controller
// Operation codes, SFR addresses, the source map and the vector table.
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

  // Number of interrupt lines that are looked at (12 to 16).
  localparam int unsigned NumLines = 16;

  localparam int unsigned LineW = 16;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned LvlW  = 2;
  localparam int unsigned VecW  = 7;

  typedef enum logic [1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpLines = 2'd2,
    OpAck   = 2'd3
  } op_e;

  localparam logic [7:0] AddrEn0 = 8'ha8;
  localparam logic [7:0] AddrEn1 = 8'he8;
  localparam logic [7:0] AddrPl0 = 8'hb8;
  localparam logic [7:0] AddrPl1 = 8'hf8;
  localparam logic [7:0] AddrPh0 = 8'hb7;
  localparam logic [7:0] AddrPh1 = 8'hf7;

  // Sources that exist: indices 0 to 6 and 8 to 11.
  localparam logic [LineW-1:0] SourceMask = 16'h0f7f;

  // Bit of the low enable register that gates every request.
  localparam int unsigned GlobalEnBit = 7;

  // The two timers are the only sources with an ack line.
  localparam logic [IdxW-1:0] IdxTimer0 = 4'd1;
  localparam logic [IdxW-1:0] IdxTimer1 = 4'd3;

  function automatic logic [VecW-1:0] vector_of(input logic [IdxW-1:0] idx);
    logic [VecW-1:0] vec;
    case (idx)
      4'd0:    vec = 7'h03;
      4'd1:    vec = 7'h0b;
      4'd2:    vec = 7'h13;
      4'd3:    vec = 7'h1b;
      4'd4:    vec = 7'h23;
      4'd5:    vec = 7'h2b;
      4'd6:    vec = 7'h33;
      4'd8:    vec = 7'h3b;
      4'd9:    vec = 7'h43;
      4'd10:   vec = 7'h4b;
      4'd11:   vec = 7'h53;
      default: vec = '0;
    endcase
    return vec;
  endfunction

  // Lines at or above NumLines never take part.
  function automatic logic [LineW-1:0] live_mask();
    logic [LineW-1:0] m;
    m = '0;
    for (int i = 0; i < LineW; i++) begin
      if (i < NumLines) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/priority_interrupt_controller_core.sv -----
// ----------------------------------------------------------------------------
// priority_interrupt_controller_core: four-level priority interrupt controller
// SFR access, line updates and ack handling with a posted request per beat.
// ----------------------------------------------------------------------------
// Usage: one input channel carries beats of four kinds (register read,
// register write, update of the 16 active-low interrupt lines, ack falling
// edge). Every input beat yields exactly one output beat with the read byte,
// the posted request (pending, level, vector) as it stands after the beat,
// and any ack pulse toward timer 0 or timer 1.
// A beat is registered at the input and evaluated from the input register;
// its result lands in the output register. One beat per cycle is sustained
// while the receiver does not stall.
// When the receiver stalls, the output register holds its beat, the input
// register holds the next one, and in_stall_o rises so the sender waits.
// Reset clears all enables and priorities, releases all lines (all ones),
// drops the outstanding request and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_interrupt_controller_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [1:0]                     op_i,
  input  wire logic [7:0]                     sfr_addr_i,
  input  wire logic [7:0]                     write_data_i,
  input  wire logic [pic_pkg::LineW-1:0]      int_lines_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [7:0]                          read_data_o,
  output logic                                irq_pending_o,
  output logic [pic_pkg::LvlW-1:0]            irq_level_o,
  output logic [pic_pkg::VecW-1:0]            vector_addr_o,
  output logic                                ack_pulse_o,
  output logic [pic_pkg::IdxW-1:0]            ack_source_o
);

  // Input register.
  logic                        in_valid_q;
  pic_pkg::op_e                op_q;
  logic [7:0]                  addr_q;
  logic [7:0]                  data_q;
  logic [pic_pkg::LineW-1:0]   lines_in_q;

  // Controller state.
  logic [pic_pkg::LineW-1:0]   en_q, en_d;
  logic [pic_pkg::LineW-1:0]   pl_q, pl_d;
  logic [pic_pkg::LineW-1:0]   ph_q, ph_d;
  logic [pic_pkg::LineW-1:0]   lines_q, lines_d;
  logic                        outst_valid_q, outst_valid_d;
  logic [pic_pkg::IdxW-1:0]    outst_idx_q, outst_idx_d;

  // Result register.
  logic                        res_valid_q;
  logic [7:0]                  rd_q, rd_d;
  logic [pic_pkg::LvlW-1:0]    lvl_q, lvl_d;
  logic [pic_pkg::VecW-1:0]    vec_q, vec_d;
  logic                        ack_q, ack_d;
  logic [pic_pkg::IdxW-1:0]    ack_src_q, ack_src_d;

  logic                        proc_fire;
  logic                        in_fire;
  logic [pic_pkg::LineW-1:0]   cand;
  logic [3:0]                  lvl_any;
  logic [pic_pkg::LvlW-1:0]    top_lvl;
  logic [pic_pkg::LineW-1:0]   top_sel;

  assign proc_fire  = in_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Apply the beat to the register file and latch the read byte.
  always_comb begin
    en_d      = en_q;
    pl_d      = pl_q;
    ph_d      = ph_q;
    lines_d   = lines_q;
    rd_d      = '0;
    ack_d     = 1'b0;
    ack_src_d = '0;
    case (op_q)
      pic_pkg::OpRead: begin
        case (addr_q)
          pic_pkg::AddrEn0: rd_d = en_q[7:0];
          pic_pkg::AddrEn1: rd_d = en_q[15:8];
          pic_pkg::AddrPl0: rd_d = pl_q[7:0];
          pic_pkg::AddrPl1: rd_d = pl_q[15:8];
          pic_pkg::AddrPh0: rd_d = ph_q[7:0];
          pic_pkg::AddrPh1: rd_d = ph_q[15:8];
          default:          rd_d = '0;
        endcase
      end
      pic_pkg::OpWrite: begin
        case (addr_q)
          pic_pkg::AddrEn0: en_d[7:0]  = data_q;
          pic_pkg::AddrEn1: en_d[15:8] = data_q;
          pic_pkg::AddrPl0: pl_d[7:0]  = data_q;
          pic_pkg::AddrPl1: pl_d[15:8] = data_q;
          pic_pkg::AddrPh0: ph_d[7:0]  = data_q;
          pic_pkg::AddrPh1: ph_d[15:8] = data_q;
          default:          en_d       = en_q;
        endcase
      end
      pic_pkg::OpLines: lines_d = lines_in_q;
      pic_pkg::OpAck: begin
        // The ack goes to the source that was outstanding before this beat.
        if (outst_valid_q &&
            (outst_idx_q == pic_pkg::IdxTimer0 || outst_idx_q == pic_pkg::IdxTimer1)) begin
          ack_d     = 1'b1;
          ack_src_d = outst_idx_q;
        end
      end
      default: lines_d = lines_q;
    endcase
  end

  // Pick the highest level among asserted, enabled sources, then the lowest
  // index within that level.
  always_comb begin
    cand    = en_d & ~lines_d & pic_pkg::SourceMask & pic_pkg::live_mask();
    lvl_any = '0;
    for (int i = 0; i < pic_pkg::LineW; i++) begin
      if (cand[i]) begin
        lvl_any[{ph_d[i], pl_d[i]}] = 1'b1;
      end
    end
    if (lvl_any[3]) begin
      top_lvl = 2'd3;
    end else if (lvl_any[2]) begin
      top_lvl = 2'd2;
    end else if (lvl_any[1]) begin
      top_lvl = 2'd1;
    end else begin
      top_lvl = 2'd0;
    end
    for (int i = 0; i < pic_pkg::LineW; i++) begin
      top_sel[i] = cand[i] && ({ph_d[i], pl_d[i]} == top_lvl);
    end
    outst_idx_d = '0;
    for (int i = pic_pkg::LineW - 1; i >= 0; i--) begin
      if (top_sel[i]) begin
        outst_idx_d = pic_pkg::IdxW'(i);
      end
    end
    outst_valid_d = en_d[pic_pkg::GlobalEnBit] && (|cand);
    if (outst_valid_d) begin
      lvl_d = top_lvl;
      vec_d = pic_pkg::vector_of(outst_idx_d);
    end else begin
      outst_idx_d = '0;
      lvl_d       = '0;
      vec_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      res_valid_q   <= 1'b0;
      en_q          <= '0;
      pl_q          <= '0;
      ph_q          <= '0;
      lines_q       <= '1;
      outst_valid_q <= 1'b0;
      outst_idx_q   <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc_fire) begin
        in_valid_q <= 1'b0;
      end
      if (proc_fire) begin
        res_valid_q   <= 1'b1;
        en_q          <= en_d;
        pl_q          <= pl_d;
        ph_q          <= ph_d;
        lines_q       <= lines_d;
        outst_valid_q <= outst_valid_d;
        outst_idx_q   <= outst_idx_d;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= pic_pkg::op_e'(op_i);
      addr_q     <= sfr_addr_i;
      data_q     <= write_data_i;
      lines_in_q <= int_lines_i;
    end
    if (proc_fire) begin
      rd_q      <= rd_d;
      lvl_q     <= lvl_d;
      vec_q     <= vec_d;
      ack_q     <= ack_d;
      ack_src_q <= ack_src_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign read_data_o   = rd_q;
  assign irq_pending_o = outst_valid_q;
  assign irq_level_o   = lvl_q;
  assign vector_addr_o = vec_q;
  assign ack_pulse_o   = ack_q;
  assign ack_source_o  = ack_src_q;

  // An ack pulse only ever reaches one of the two timers.
  a_ack_timer_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ack_pulse_o) |->
      (ack_source_o == pic_pkg::IdxTimer0 || ack_source_o == pic_pkg::IdxTimer1))
    else $error("ack pulse sent to a source without an ack line");

  // No posted request means level and vector read as zero.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !irq_pending_o) |-> (irq_level_o == '0 && vector_addr_o == '0))
    else $error("level or vector nonzero without a pending request");

  // A request is only outstanding while the global enable is set.
  a_global_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_valid_q |-> en_q[pic_pkg::GlobalEnBit])
    else $error("request outstanding with global enable clear");

  // A processed beat always lands in the result register on the next edge.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |=> out_valid_o)
    else $error("processed beat did not produce a result");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the priority interrupt controller core
// A queue-fed driver sends register reads and writes, interrupt line updates
// and ack edges. A predictor keeps its own copy of the SFRs and the posted
// request and checks every output beat field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pic_pkg::*;

  localparam int unsigned NumBeats   = 1050;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;

  typedef struct packed {
    op_e        op;
    logic [7:0] addr;
    logic [7:0] data;
    logic [15:0] lines;
  } beat_t;

  typedef struct packed {
    logic [7:0]      read_data;
    logic            pending;
    logic [LvlW-1:0] level;
    logic [VecW-1:0] vector;
    logic            ack;
    logic [IdxW-1:0] ack_src;
  } irq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  op_e                 op = OpRead;
  logic [7:0]          sfr_addr = '0;
  logic [7:0]          wdata = '0;
  logic [LineW-1:0]    int_lines = '1;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          rd_data;
  logic                irq_pending;
  logic [LvlW-1:0]     irq_level;
  logic [VecW-1:0]     vector_addr;
  logic                ack_pulse;
  logic [IdxW-1:0]     ack_source;

  beat_t       beat_q[$];
  irq_result_t irq_expect_q[$];

  // Predicted controller state.
  logic [15:0]     en_q = '0;
  logic [15:0]     pl_q = '0;
  logic [15:0]     ph_q = '0;
  logic [15:0]     lines_q = '1;
  logic            posted_q = 1'b0;
  logic [IdxW-1:0] posted_idx_q = '0;

  int unsigned accepted = 0;
  int unsigned checked = 0;
  int unsigned mismatches = 0;
  int unsigned failures = 0;
  int unsigned posted_seen = 0;
  int unsigned acks_seen = 0;
  int unsigned cycles = 0;

  priority_interrupt_controller_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .sfr_addr_i    (sfr_addr),
    .write_data_i  (wdata),
    .int_lines_i   (int_lines),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_o   (rd_data),
    .irq_pending_o (irq_pending),
    .irq_level_o   (irq_level),
    .vector_addr_o (vector_addr),
    .ack_pulse_o   (ack_pulse),
    .ack_source_o  (ack_source)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] sfr_addr_at(int k);
    case (k)
      0: return AddrEn0;
      1: return AddrEn1;
      2: return AddrPl0;
      3: return AddrPl1;
      4: return AddrPh0;
      default: return AddrPh1;
    endcase
  endfunction

  // Fields that the operation does not use get random content.
  function automatic void push_beat(op_e o, logic [7:0] a, logic [7:0] d, logic [15:0] ln);
    beat_t b;
    b.op    = o;
    b.addr  = (o == OpRead || o == OpWrite) ? a : 8'($urandom);
    b.data  = (o == OpWrite) ? d : 8'($urandom);
    b.lines = (o == OpLines) ? ln : 16'($urandom);
    beat_q.push_back(b);
  endfunction

  // Applies one beat to the predicted state and returns the output beat it causes.
  function automatic irq_result_t resolve_beat(beat_t b);
    irq_result_t r;
    logic [15:0] cand;
    logic [31:0] live;
    logic [1:0]  lvl;
    logic        found;
    int          slot;
    r = '0;
    case (b.op)
      OpRead: begin
        case (b.addr)
          AddrEn0: r.read_data = en_q[7:0];
          AddrEn1: r.read_data = en_q[15:8];
          AddrPl0: r.read_data = pl_q[7:0];
          AddrPl1: r.read_data = pl_q[15:8];
          AddrPh0: r.read_data = ph_q[7:0];
          AddrPh1: r.read_data = ph_q[15:8];
          default: r.read_data = '0;
        endcase
      end
      OpWrite: begin
        case (b.addr)
          AddrEn0: en_q[7:0] = b.data;
          AddrEn1: en_q[15:8] = b.data;
          AddrPl0: pl_q[7:0] = b.data;
          AddrPl1: pl_q[15:8] = b.data;
          AddrPh0: ph_q[7:0] = b.data;
          AddrPh1: ph_q[15:8] = b.data;
          default: ;
        endcase
      end
      OpLines: lines_q = b.lines;
      default: begin
        // The ack goes to the request posted before this beat.
        if (posted_q && (posted_idx_q == IdxTimer0 || posted_idx_q == IdxTimer1)) begin
          r.ack     = 1'b1;
          r.ack_src = posted_idx_q;
        end
      end
    endcase

    live  = (32'd1 << NumLines) - 32'd1;
    cand  = en_q & ~lines_q & SourceMask & live[15:0];
    found = 1'b0;
    posted_idx_q = '0;
    if (en_q[GlobalEnBit]) begin
      for (int i = 0; i < 16; i++) begin
        if (cand[i]) begin
          lvl = {ph_q[i], pl_q[i]};
          if (!found || lvl > r.level) begin
            found        = 1'b1;
            r.level      = lvl;
            posted_idx_q = 4'(i);
          end
        end
      end
    end
    posted_q  = found;
    r.pending = found;
    if (found) begin
      // Vectors are spaced by eight; index 7 has no slot.
      slot     = (posted_idx_q < 8) ? int'(posted_idx_q) : int'(posted_idx_q) - 1;
      r.vector = 7'(slot * 8 + 3);
    end else begin
      r.level = '0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < 10) begin
        $display("mismatch on beat %0d: %s expected %0h, got %0h", checked, name, exp_v,
                 act_v);
      end
      mismatches++;
      failures++;
    end
  endfunction

  // Driver: a payload is held until it is taken.
  always @(posedge clk) begin
    beat_t nxt;
    int    idle;
    idle = (accepted < NumBeats / 3) ? 24 : (accepted < 2 * NumBeats / 3) ? 76 : 0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        irq_expect_q.push_back(resolve_beat('{op, sfr_addr, wdata, int_lines}));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() > 0 && $urandom_range(0, 99) >= idle) begin
          nxt = beat_q.pop_front();
          in_valid  <= 1'b1;
          op        <= nxt.op;
          sfr_addr  <= nxt.addr;
          wdata     <= nxt.data;
          int_lines <= nxt.lines;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output beat with the oldest prediction.
  always @(posedge clk) begin
    irq_result_t exp_r;
    int          idle;
    idle = (accepted < NumBeats / 3) ? 76 : (accepted < 2 * NumBeats / 3) ? 24 : 0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (irq_expect_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("output beat with no prediction pending");
          end
          mismatches++;
          failures++;
        end else begin
          exp_r = irq_expect_q.pop_front();
          check_field("read_data", 16'(exp_r.read_data), 16'(rd_data));
          check_field("irq_pending", 16'(exp_r.pending), 16'(irq_pending));
          check_field("irq_level", 16'(exp_r.level), 16'(irq_level));
          check_field("vector_addr", 16'(exp_r.vector), 16'(vector_addr));
          check_field("ack_pulse", 16'(exp_r.ack), 16'(ack_pulse));
          check_field("ack_source", 16'(exp_r.ack_src), 16'(ack_source));
          if (exp_r.pending) posted_seen++;
          if (exp_r.ack) acks_seen++;
          checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats checked", cycles, checked);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int          k;
    logic [7:0]  d;
    logic [15:0] ln;
    int unsigned total;

    // Directed part: reset values, global enable, ties, both timer acks,
    // sources that do not exist, unmapped addresses and field extremes.
    push_beat(OpRead, AddrEn0, 8'h00, 16'h0000);
    push_beat(OpLines, 8'h00, 8'h00, 16'h0000);
    push_beat(OpWrite, AddrEn0, 8'h7f, 16'h0000);
    push_beat(OpWrite, AddrEn1, 8'hff, 16'h0000);
    push_beat(OpAck, 8'h00, 8'h00, 16'h0000);
    push_beat(OpWrite, AddrEn0, 8'hff, 16'h0000);
    push_beat(OpAck, 8'h00, 8'h00, 16'h0000);
    push_beat(OpWrite, AddrPh0, 8'h02, 16'h0000);
    push_beat(OpAck, 8'h00, 8'h00, 16'h0000);
    push_beat(OpWrite, AddrPl0, 8'h08, 16'h0000);
    push_beat(OpWrite, AddrPh0, 8'h0a, 16'h0000);
    push_beat(OpAck, 8'h00, 8'h00, 16'h0000);
    push_beat(OpWrite, AddrPh1, 8'hff, 16'h0000);
    push_beat(OpWrite, AddrPl1, 8'hff, 16'h0000);
    push_beat(OpLines, 8'h00, 8'h00, 16'h0f7f);
    push_beat(OpLines, 8'h00, 8'h00, 16'hffff);
    push_beat(OpWrite, 8'hff, 8'hff, 16'h0000);
    push_beat(OpRead, 8'h00, 8'h00, 16'h0000);
    for (int i = 1; i < 6; i++) push_beat(OpRead, sfr_addr_at(i), 8'h00, 16'h0000);
    push_beat(OpLines, 8'h00, 8'h00, 16'hf7ff);
    push_beat(OpWrite, AddrEn0, 8'h00, 16'h0000);

    // Random part: mostly program-then-trigger-then-ack groups, some noise.
    while (beat_q.size() < NumBeats) begin
      if ($urandom_range(0, 99) < 12) begin
        push_beat(op_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 16'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) begin
          k = $urandom_range(0, 5);
          d = 8'($urandom);
          if (k == 0 && $urandom_range(0, 99) < 85) d[GlobalEnBit] = 1'b1;
          push_beat(OpWrite, sfr_addr_at(k), d, 16'h0000);
        end
        case ($urandom_range(0, 3))
          0: ln = 16'($urandom);
          1: ln = ~(16'd1 << $urandom_range(0, 15));
          2: ln = ~(16'($urandom) & 16'($urandom));
          default: ln = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        endcase
        push_beat(OpLines, 8'h00, 8'h00, ln);
        if ($urandom_range(0, 99) < 70) push_beat(OpAck, 8'h00, 8'h00, 16'h0000);
        if ($urandom_range(0, 99) < 40) begin
          push_beat(OpRead, sfr_addr_at($urandom_range(0, 5)), 8'h00, 16'h0000);
        end
      end
    end
    total = beat_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted != total) @(posedge clk);
    while (irq_expect_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (irq_expect_q.size() != 0) failures++;

    $display("%0d beats sent and %0d output beats checked, %0d mismatches", total, checked,
             mismatches);
    $display("%0d beats with a posted request, %0d timer ack pulses", posted_seen, acks_seen);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pic_pkg.sv
hdl/priority_interrupt_controller_core.sv
tb/tb.sv
